// ===== rtl/pvsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pvsc_pkg
// Shared types, codes and constants of the variable-step PID controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvsc_pkg;

  // Intermediate arithmetic is 64-bit signed with saturation.
  localparam int WIDE_W    = 64;
  localparam int PROD_W    = 2 * WIDE_W;
  localparam int MUL_DIG   = 4;
  localparam int MUL_STEPS = WIDE_W / MUL_DIG;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int DIV_CNT_W = $clog2(WIDE_W);

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [WIDE_W-1:0]        mag_t;
  typedef logic [PROD_W-1:0]        prod_t;

  localparam mag_t  US_PER_S = mag_t'(64'd1000000);
  localparam prod_t SAT_POS  = prod_t'(64'h7fff_ffff_ffff_ffff);
  localparam prod_t SAT_NEG  = prod_t'(64'h8000_0000_0000_0000);

  // Divide by one million: drop 2^6, then multiply by ceil(2^72 / 15625)
  // and keep the bits above 2^72; exact for dividends up to 2^63.
  localparam int   US_POW2   = 6;
  localparam mag_t US_RCP    = mag_t'(64'd302231454903657294);
  localparam int   RCP_SHIFT = 72;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_FLOOR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CEILING   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_FLOOR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_CEILING = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MODE  = 3'd7;

  // Limit reset values
  localparam wide_t RST_OUT_FLOOR     = -64'sd65536;
  localparam wide_t RST_OUT_CEILING   = 64'sd65536;
  localparam wide_t RST_INTEG_FLOOR   = -64'sd65536000;
  localparam wide_t RST_INTEG_CEILING = 64'sd65536000;

  // Multiplier operand selects
  localparam int MSEL_W = 3;
  localparam logic [MSEL_W-1:0] MSEL_ERR_STEP = 3'd0;
  localparam logic [MSEL_W-1:0] MSEL_DIFF_US  = 3'd1;
  localparam logic [MSEL_W-1:0] MSEL_PROP     = 3'd2;
  localparam logic [MSEL_W-1:0] MSEL_INTEG    = 3'd3;
  localparam logic [MSEL_W-1:0] MSEL_DERIV    = 3'd4;
  localparam logic [MSEL_W-1:0] MSEL_RECIP    = 3'd5;

  typedef struct packed {
    logic              load;
    logic              mul_start;
    logic [MSEL_W-1:0] mul_sel;
    logic              div_start;
    logic              integ_upd;
    logic              rate_upd;
    logic              rate_zero;
    logic              sum_init;
    logic              sum_add;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic step_zero;
  } sts_t;

  function automatic mag_t abs_w(input wide_t x);
    return x[WIDE_W-1] ? mag_t'(-x) : mag_t'(x);
  endfunction

endpackage

// ===== rtl/pid_variable_step_controller_unit.sv =====
// ----------------------------------------------------------------------------
// pid_variable_step_controller_unit
// PID controller with variable time step and anti-windup, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item: a command (control
//   step or clear), measurement, setpoint and a microsecond time stamp.
//   Output channel (out_valid/out_ready) returns one item per input: the
//   clamped drive value and a flag set when a drive limit was hit.
//   Configuration writes (cfg_we/cfg_idx/cfg_wdata) take effect at once and
//   belong to idle periods.
//   One item is worked at a time. A control step runs six products on the
//   shared serial multiplier, one being the reciprocal product that divides
//   by one million, and one rate quotient on the bit-serial divider; with no
//   elapsed time the rate product and quotient are skipped. A clear skips
//   the arithmetic and goes straight to the output.
//   The input is taken again as soon as the sequencer returns to idle, even
//   while a finished result waits in the output register; a stalled receiver
//   holds the next result in the sequencer until the register frees.
//   Synchronous reset restores the default gains and limits, clears the
//   integral, previous error and last time stamp, and empties the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_variable_step_controller_unit #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int STEP_WIDTH  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pvsc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [VALUE_WIDTH-1:0]            cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic signed [VALUE_WIDTH-1:0]     in_measured,
  input  logic signed [VALUE_WIDTH-1:0]     in_target,
  input  logic [63:0]                       in_stamp_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [VALUE_WIDTH-1:0]     out_drive,
  output logic                              out_clamped
);

  pvsc_pkg::cmd_t cmd;
  pvsc_pkg::sts_t sts;

  pvsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pvsc_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .STEP_WIDTH  (STEP_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .in_func     (in_func),
    .in_measured (in_measured),
    .in_target   (in_target),
    .in_stamp_us (in_stamp_us),
    .cmd         (cmd),
    .sts         (sts),
    .out_drive   (out_drive),
    .out_clamped (out_clamped)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after an accept");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.mul_done && sts.div_done))
    else $error("multiplier and divider finished together");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  a_start_single: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mul_start && cmd.div_start))
    else $error("two arithmetic units started at once");
`endif

endmodule

// ===== rtl/pvsc_mul.sv =====
// ----------------------------------------------------------------------------
// pvsc_mul
// Serial sign-magnitude multiplier, one 4-bit digit per cycle, 64-bit
// saturated signed result and the full unsigned magnitude product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvsc_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  pvsc_pkg::mag_t       a_mag,
  input  pvsc_pkg::mag_t       b_mag,
  input  logic                 neg,
  output logic                 done,
  output pvsc_pkg::wide_t      res,
  output pvsc_pkg::prod_t      prod
);

  logic                            busy_r;
  logic                            fin_r;
  logic                            done_r;
  logic [pvsc_pkg::MUL_CNT_W-1:0]  cnt_r;
  pvsc_pkg::prod_t                 acc_r;
  pvsc_pkg::prod_t                 ash_r;
  pvsc_pkg::mag_t                  b_r;
  logic                            neg_r;
  pvsc_pkg::wide_t                 res_r;
  pvsc_pkg::prod_t                 lim;
  pvsc_pkg::prod_t                 clip;
  pvsc_pkg::prod_t                 part;

  always_comb begin
    lim  = neg_r ? pvsc_pkg::SAT_NEG : pvsc_pkg::SAT_POS;
    clip = (acc_r > lim) ? lim : acc_r;
    part = pvsc_pkg::prod_t'(ash_r *
           pvsc_pkg::prod_t'(b_r[pvsc_pkg::MUL_DIG-1:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        ash_r  <= pvsc_pkg::prod_t'(a_mag);
        b_r    <= b_mag;
        neg_r  <= neg;
      end else if (busy_r) begin
        acc_r <= acc_r + part;
        ash_r <= ash_r << pvsc_pkg::MUL_DIG;
        b_r   <= b_r >> pvsc_pkg::MUL_DIG;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pvsc_pkg::MUL_CNT_W'(pvsc_pkg::MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        // negate the clipped magnitude; 2^63 wraps to the most negative value
        res_r  <= neg_r ? -pvsc_pkg::wide_t'(clip[pvsc_pkg::WIDE_W-1:0])
                        : pvsc_pkg::wide_t'(clip[pvsc_pkg::WIDE_W-1:0]);
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign prod = acc_r;

endmodule

// ===== rtl/pvsc_div.sv =====
// ----------------------------------------------------------------------------
// pvsc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvsc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  pvsc_pkg::mag_t   num,
  input  pvsc_pkg::mag_t   den,
  output logic             done,
  output pvsc_pkg::mag_t   quo
);

  logic                            busy_r;
  logic                            done_r;
  logic [pvsc_pkg::DIV_CNT_W-1:0]  cnt_r;
  pvsc_pkg::mag_t                  rem_r;
  pvsc_pkg::mag_t                  q_r;
  pvsc_pkg::mag_t                  den_r;
  logic [pvsc_pkg::WIDE_W:0]       rsh;
  logic [pvsc_pkg::WIDE_W:0]       rsub;
  logic                            ge;

  always_comb begin
    rsh  = {rem_r, q_r[pvsc_pkg::WIDE_W-1]};
    rsub = rsh - {1'b0, den_r};
    ge   = (rsh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        q_r    <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= ge ? rsub[pvsc_pkg::WIDE_W-1:0] : rsh[pvsc_pkg::WIDE_W-1:0];
        q_r   <= {q_r[pvsc_pkg::WIDE_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pvsc_pkg::DIV_CNT_W'(pvsc_pkg::WIDE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== rtl/pvsc_dp.sv =====
// ----------------------------------------------------------------------------
// pvsc_dp
// Datapath: configuration registers, controller state, operand selection,
// shared multiplier and divider, integral and output clamps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvsc_dp #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int STEP_WIDTH  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pvsc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [VALUE_WIDTH-1:0]               cfg_wdata,
  input  logic                                 in_func,
  input  logic signed [VALUE_WIDTH-1:0]        in_measured,
  input  logic signed [VALUE_WIDTH-1:0]        in_target,
  input  logic [63:0]                          in_stamp_us,
  input  pvsc_pkg::cmd_t                       cmd,
  output pvsc_pkg::sts_t                       sts,
  output logic signed [VALUE_WIDTH-1:0]        out_drive,
  output logic                                 out_clamped
);

  localparam int V = VALUE_WIDTH;
  localparam int W = pvsc_pkg::WIDE_W;

  typedef logic signed [V-1:0] val_t;

  function automatic pvsc_pkg::wide_t sx(input val_t x);
    return {{(W-V){x[V-1]}}, x};
  endfunction

  // configuration
  val_t kp_r, ki_r, kd_r, ofl_r, oce_r, ifl_r, ice_r;
  logic rev_r;

  // controller state
  logic [63:0]             last_stamp_r;
  val_t                    err_r;
  val_t                    prev_r;
  val_t                    integ_r;
  logic [STEP_WIDTH-1:0]   step_r;
  pvsc_pkg::wide_t         rate_r;
  pvsc_pkg::wide_t         sum_r;
  logic                    clr_r;
  logic                    div_neg_r;
  val_t                    drive_r;
  logic                    clamped_r;

  // load path
  logic signed [V:0]       dv;
  val_t                    err_nxt;
  logic [63:0]             sdiff;
  logic [STEP_WIDTH-1:0]   step_nxt;

  // operands
  logic signed [V:0]       dif;
  pvsc_pkg::wide_t         opa;
  pvsc_pkg::wide_t         opb;
  logic                    mul_done;
  pvsc_pkg::wide_t         mul_res;
  pvsc_pkg::prod_t         mul_prod;
  logic                    div_done;
  pvsc_pkg::mag_t          div_quo;
  pvsc_pkg::mag_t          den;

  // integral update
  pvsc_pkg::mag_t          quo_i;
  pvsc_pkg::wide_t         incr;
  pvsc_pkg::wide_t         rate_q;
  logic signed [W:0]       isum;
  logic signed [W:0]       vmax;
  logic signed [W:0]       vmin;
  val_t                    isat;
  val_t                    integ_nxt;

  // output sum
  pvsc_pkg::wide_t         term;
  logic signed [W:0]       ssum;
  pvsc_pkg::wide_t         sum_sat;
  val_t                    drive_nxt;
  logic                    clamped_nxt;

  always_comb begin
    dv = rev_r ? ({in_measured[V-1], in_measured} - {in_target[V-1], in_target})
               : ({in_target[V-1], in_target} - {in_measured[V-1], in_measured});
    if (dv[V] != dv[V-1]) begin
      err_nxt = dv[V] ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}};
    end else begin
      err_nxt = dv[V-1:0];
    end
    sdiff    = in_stamp_us - last_stamp_r;
    step_nxt = '0;
    if (last_stamp_r != 64'd0 && in_stamp_us > last_stamp_r) begin
      step_nxt = (|sdiff[63:STEP_WIDTH]) ? {STEP_WIDTH{1'b1}} : sdiff[STEP_WIDTH-1:0];
    end
  end

  always_comb begin
    dif = {err_r[V-1], err_r} - {prev_r[V-1], prev_r};
    unique case (cmd.mul_sel)
      pvsc_pkg::MSEL_ERR_STEP: begin
        opa = sx(err_r);
        opb = {{(W-STEP_WIDTH){1'b0}}, step_r};
      end
      pvsc_pkg::MSEL_DIFF_US: begin
        opa = {{(W-V-1){dif[V]}}, dif};
        opb = pvsc_pkg::wide_t'(pvsc_pkg::US_PER_S);
      end
      pvsc_pkg::MSEL_PROP: begin
        opa = sx(kp_r);
        opb = sx(err_r);
      end
      pvsc_pkg::MSEL_INTEG: begin
        opa = sx(ki_r);
        opb = sx(integ_r);
      end
      pvsc_pkg::MSEL_DERIV: begin
        opa = sx(kd_r);
        opb = rate_r;
      end
      pvsc_pkg::MSEL_RECIP: begin
        // magnitude of the held error-times-step product over 2^6
        opa = pvsc_pkg::wide_t'(pvsc_pkg::abs_w(mul_res) >> pvsc_pkg::US_POW2);
        opb = pvsc_pkg::wide_t'(pvsc_pkg::US_RCP);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    den = {{(W-STEP_WIDTH){1'b0}}, step_r};
  end

  pvsc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a_mag (pvsc_pkg::abs_w(opa)),
    .b_mag (pvsc_pkg::abs_w(opb)),
    .neg   (opa[W-1] ^ opb[W-1]),
    .done  (mul_done),
    .res   (mul_res),
    .prod  (mul_prod)
  );

  pvsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (pvsc_pkg::abs_w(mul_res)),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    quo_i  = {{(W + pvsc_pkg::RCP_SHIFT - pvsc_pkg::PROD_W){1'b0}},
              mul_prod[pvsc_pkg::PROD_W-1:pvsc_pkg::RCP_SHIFT]};
    incr   = div_neg_r ? -pvsc_pkg::wide_t'(quo_i) : pvsc_pkg::wide_t'(quo_i);
    rate_q = div_neg_r ? -pvsc_pkg::wide_t'(div_quo) : pvsc_pkg::wide_t'(div_quo);
    isum = {integ_r[V-1], sx(integ_r)} + {incr[W-1], incr};
    vmax = {{(W+2-V){1'b0}}, {(V-1){1'b1}}};
    vmin = ~vmax;
    if (isum > vmax) begin
      isat = {1'b0, {(V-1){1'b1}}};
    end else if (isum < vmin) begin
      isat = {1'b1, {(V-1){1'b0}}};
    end else begin
      isat = isum[V-1:0];
    end
    // ceiling first, so with crossed limits a value above the ceiling takes the ceiling
    if (isat > ice_r) begin
      integ_nxt = ice_r;
    end else if (isat < ifl_r) begin
      integ_nxt = ifl_r;
    end else begin
      integ_nxt = isat;
    end
  end

  always_comb begin
    term = mul_res >>> FRAC_BITS;
    ssum = {sum_r[W-1], sum_r} + {term[W-1], term};
    if (ssum[W] != ssum[W-1]) begin
      sum_sat = ssum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      sum_sat = ssum[W-1:0];
    end
    clamped_nxt = 1'b0;
    if (clr_r) begin
      drive_nxt = '0;
    end else if (sum_r > sx(oce_r)) begin
      drive_nxt   = oce_r;
      clamped_nxt = 1'b1;
    end else if (sum_r < sx(ofl_r)) begin
      drive_nxt   = ofl_r;
      clamped_nxt = 1'b1;
    end else begin
      drive_nxt = sum_r[V-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= '0;
      ki_r  <= '0;
      kd_r  <= '0;
      ofl_r <= V'(pvsc_pkg::RST_OUT_FLOOR);
      oce_r <= V'(pvsc_pkg::RST_OUT_CEILING);
      ifl_r <= V'(pvsc_pkg::RST_INTEG_FLOOR);
      ice_r <= V'(pvsc_pkg::RST_INTEG_CEILING);
      rev_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pvsc_pkg::REG_PROP_GAIN:     kp_r  <= cfg_wdata;
        pvsc_pkg::REG_INTEG_GAIN:    ki_r  <= cfg_wdata;
        pvsc_pkg::REG_DERIV_GAIN:    kd_r  <= cfg_wdata;
        pvsc_pkg::REG_OUT_FLOOR:     ofl_r <= cfg_wdata;
        pvsc_pkg::REG_OUT_CEILING:   oce_r <= cfg_wdata;
        pvsc_pkg::REG_INTEG_FLOOR:   ifl_r <= cfg_wdata;
        pvsc_pkg::REG_INTEG_CEILING: ice_r <= cfg_wdata;
        pvsc_pkg::REG_REVERSE_MODE:  rev_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r <= '0;
      integ_r      <= '0;
      prev_r       <= '0;
      clr_r        <= 1'b0;
    end else begin
      if (cmd.load) begin
        clr_r <= in_func;
        if (in_func) begin
          integ_r <= '0;
          prev_r  <= '0;
        end else begin
          err_r        <= err_nxt;
          step_r       <= step_nxt;
          last_stamp_r <= in_stamp_us;
        end
      end
      if (cmd.div_start ||
          (cmd.mul_start && cmd.mul_sel == pvsc_pkg::MSEL_RECIP)) begin
        div_neg_r <= mul_res[W-1];
      end
      if (cmd.integ_upd) begin
        integ_r <= integ_nxt;
      end
      if (cmd.rate_upd) begin
        rate_r <= rate_q;
        prev_r <= err_r;
      end
      if (cmd.rate_zero) begin
        rate_r <= '0;
        prev_r <= err_r;
      end
      if (cmd.sum_init) begin
        sum_r <= term;
      end
      if (cmd.sum_add) begin
        sum_r <= sum_sat;
      end
      if (cmd.out_load) begin
        drive_r   <= drive_nxt;
        clamped_r <= clamped_nxt;
      end
    end
  end

  assign sts.mul_done  = mul_done;
  assign sts.div_done  = div_done;
  assign sts.step_zero = (step_r == '0);
  assign out_drive     = drive_r;
  assign out_clamped   = clamped_r;

endmodule

// ===== rtl/pvsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pvsc_ctrl
// Sequencer: steps the datapath through integral, optional rate and term products,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvsc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_func,
  output logic             out_valid,
  input  logic             out_ready,
  input  pvsc_pkg::sts_t   sts,
  output pvsc_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_I_MUL = 4'd1;
  localparam logic [3:0] S_I_RCP = 4'd2;
  localparam logic [3:0] S_R_MUL = 4'd3;
  localparam logic [3:0] S_R_DIV = 4'd4;
  localparam logic [3:0] S_P_MUL = 4'd5;
  localparam logic [3:0] S_K_MUL = 4'd6;
  localparam logic [3:0] S_D_MUL = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       go_r, go_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    go_nxt    = 1'b0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_func) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_I_MUL;
            go_nxt    = 1'b1;
          end
        end
      end
      S_I_MUL: begin
        cmd.mul_start = go_r;
        cmd.mul_sel   = pvsc_pkg::MSEL_ERR_STEP;
        if (sts.mul_done) begin
          state_nxt = S_I_RCP;
          go_nxt    = 1'b1;
        end
      end
      S_I_RCP: begin
        cmd.mul_start = go_r;
        cmd.mul_sel   = pvsc_pkg::MSEL_RECIP;
        if (sts.mul_done) begin
          cmd.integ_upd = 1'b1;
          go_nxt        = 1'b1;
          // no elapsed time: skip the rate product and divide, zero the rate
          if (sts.step_zero) begin
            cmd.rate_zero = 1'b1;
            state_nxt     = S_P_MUL;
          end else begin
            state_nxt = S_R_MUL;
          end
        end
      end
      S_R_MUL: begin
        cmd.mul_start = go_r;
        cmd.mul_sel   = pvsc_pkg::MSEL_DIFF_US;
        if (sts.mul_done) begin
          state_nxt = S_R_DIV;
          go_nxt    = 1'b1;
        end
      end
      S_R_DIV: begin
        cmd.div_start = go_r;
        if (sts.div_done) begin
          cmd.rate_upd = 1'b1;
          state_nxt    = S_P_MUL;
          go_nxt       = 1'b1;
        end
      end
      S_P_MUL: begin
        cmd.mul_start = go_r;
        cmd.mul_sel   = pvsc_pkg::MSEL_PROP;
        if (sts.mul_done) begin
          cmd.sum_init = 1'b1;
          state_nxt    = S_K_MUL;
          go_nxt       = 1'b1;
        end
      end
      S_K_MUL: begin
        cmd.mul_start = go_r;
        cmd.mul_sel   = pvsc_pkg::MSEL_INTEG;
        if (sts.mul_done) begin
          cmd.sum_add = 1'b1;
          state_nxt   = S_D_MUL;
          go_nxt      = 1'b1;
        end
      end
      S_D_MUL: begin
        cmd.mul_start = go_r;
        cmd.mul_sel   = pvsc_pkg::MSEL_DERIV;
        if (sts.mul_done) begin
          cmd.sum_add = 1'b1;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
